>>> rtl/supply_voltage_filter_monitor_macros.svh
// assertion macros for the supply voltage filter monitor checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef SUPPLY_VOLTAGE_FILTER_MONITOR_MACROS_SVH
`define SUPPLY_VOLTAGE_FILTER_MONITOR_MACROS_SVH

// same-cycle implication
`define SVFM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svfm check failed");

// next-cycle implication
`define SVFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svfm check failed");

`endif

>>> rtl/svfm_pkg.sv
// types and constants shared by the supply voltage filter monitor
// no dependencies
package svfm_pkg;

  localparam int ADC_W      = 16;
  localparam int MV_W       = 13;
  localparam int MVRAW_W    = 14;
  localparam int PROD_W     = 30;
  localparam int HYST_W     = 10;
  localparam int DEB_W      = 4;
  localparam int WARM_W     = 6;
  localparam int LVL_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MVRAW_W-1:0] MV_SCALE      = 14'd8580;
  localparam logic [MVRAW_W-1:0] VALID_LOW_MV  = 14'd3000;
  localparam logic [MVRAW_W-1:0] VALID_HIGH_MV = 14'd7000;
  localparam logic [MV_W-1:0]    ENGAGE_MIN_MV = 13'd2500;

  localparam logic [MV_W-1:0]   RST_LEVEL1   = 13'd4300;
  localparam logic [MV_W-1:0]   RST_LEVEL2   = 13'd4150;
  localparam logic [MV_W-1:0]   RST_LEVEL3   = 13'd3950;
  localparam logic [HYST_W-1:0] RST_HYST     = 10'd130;
  localparam logic [DEB_W-1:0]  RST_DEBOUNCE = 4'd3;
  localparam logic [WARM_W-1:0] RST_WARMUP   = 6'd20;
  localparam logic [MV_W-1:0]   RST_SPREAD   = 13'd300;
  localparam logic [MV_W-1:0]   RST_CEILING  = 13'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL1   = 3'd0,
    CFG_LEVEL2   = 3'd1,
    CFG_LEVEL3   = 3'd2,
    CFG_HYST     = 3'd3,
    CFG_DEBOUNCE = 3'd4,
    CFG_WARMUP   = 3'd5,
    CFG_SPREAD   = 3'd6,
    CFG_CEILING  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [MV_W-1:0]   level1;
    logic [MV_W-1:0]   level2;
    logic [MV_W-1:0]   level3;
    logic [HYST_W-1:0] hyst;
    logic [DEB_W-1:0]  debounce;
    logic [WARM_W-1:0] warmup;
    logic [MV_W-1:0]   spread;
    logic [MV_W-1:0]   ceiling;
  } cfg_t;

  typedef struct packed {
    logic            acc;
    logic [MV_W-1:0] mv;
  } sample_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_SCAN_END,
    ST_RING_FV,
    ST_RING_DIV,
    ST_HIST_WRITE,
    ST_HIST_SCAN,
    ST_HIST_FV,
    ST_HIST_DIV,
    ST_LEVEL,
    ST_DONE
  } back_state_t;

endpackage

>>> rtl/svfm_if.sv
// channel interfaces of the supply voltage filter monitor
// depends on svfm_pkg
interface svfm_in_if;
  logic                        valid;
  logic                        ready;
  logic [svfm_pkg::ADC_W-1:0]  adc_sample;
  modport source (output valid, adc_sample, input ready);
  modport sink (input valid, adc_sample, output ready);
endinterface

interface svfm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [svfm_pkg::MV_W-1:0]   smoothed_mv;
  logic [svfm_pkg::LVL_W-1:0]  warn_level;
  logic                        low_voltage;
  logic                        level_changed;
  modport source (output valid, accepted, smoothed_mv, warn_level, low_voltage,
                  level_changed, input ready);
  modport sink (input valid, accepted, smoothed_mv, warn_level, low_voltage,
                level_changed, output ready);
endinterface

interface svfm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [svfm_pkg::CFG_IDX_W-1:0]   index;
  logic [svfm_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/svfm_fifo.sv
// short queue between the front and back parts
// depends on svfm_pkg
module svfm_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  svfm_pkg::sample_t push_data,
  output logic              full,
  input  logic              pop,
  output svfm_pkg::sample_t pop_data,
  output logic              empty
);
  localparam int PW = $clog2(svfm_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(svfm_pkg::QUEUE_DEPTH + 1);

  svfm_pkg::sample_t mem_r [svfm_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(svfm_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end
endmodule

>>> rtl/svfm_div.sv
// restoring divider, one quotient bit per cycle
// no package dependencies
module svfm_div #(
  parameter int DVD_W = 19,
  parameter int DVS_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int NW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [NW-1:0]    cnt_r;
  logic             run_r, done_r;
  logic [DVS_W:0]   shifted;
  logic             fits;

  assign shifted  = {rem_r, quo_r[DVD_W-1]};
  assign fits     = (shifted >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= fits ? DVS_W'(shifted - {1'b0, dvs_r}) : DVS_W'(shifted);
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= NW'(DVD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/svfm_front.sv
// front part: millivolt conversion, range check and warm-up
// depends on svfm_pkg and svfm_if
module svfm_front (
  input  logic               clk,
  input  logic               rst_n,
  svfm_in_if.sink            in_ch,
  input  svfm_pkg::cfg_t     cfg,
  input  logic               full,
  output logic               push,
  output svfm_pkg::sample_t  push_data
);
  logic [svfm_pkg::PROD_W-1:0]  prod;
  logic [svfm_pkg::MVRAW_W-1:0] mv_raw;
  logic [svfm_pkg::WARM_W-1:0]  warm_r;
  logic in_range, warm_busy;

  assign prod      = svfm_pkg::PROD_W'(in_ch.adc_sample)
                   * svfm_pkg::PROD_W'(svfm_pkg::MV_SCALE);
  assign mv_raw    = prod[svfm_pkg::PROD_W-1:16];
  assign in_range  = (mv_raw >= svfm_pkg::VALID_LOW_MV) && (mv_raw <= svfm_pkg::VALID_HIGH_MV);
  assign warm_busy = (warm_r < cfg.warmup);

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;
  assign push_data.acc = in_range && !warm_busy;
  assign push_data.mv  = (mv_raw > {1'b0, cfg.ceiling}) ? cfg.ceiling
                                                        : mv_raw[svfm_pkg::MV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
    end else if (push && in_range && warm_busy) begin
      warm_r <= warm_r + 1'b1;
    end
  end
endmodule

>>> rtl/svfm_back.sv
// back part: sample ring scan, history average and level debounce
// depends on svfm_pkg, svfm_if and svfm_div
module svfm_back #(
  parameter int RING_DEPTH    = 60,
  parameter int HISTORY_DEPTH = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  svfm_pkg::cfg_t    cfg,
  input  logic              empty,
  input  svfm_pkg::sample_t pop_data,
  output logic              pop,
  svfm_out_if.source        out_ch
);
  localparam int MW     = svfm_pkg::MV_W;
  localparam int RW     = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = MW + CNT_W;
  localparam int HW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HCNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int HSUM_W = MW + HCNT_W;
  localparam int DVD_W  = (SUM_W > HSUM_W) ? SUM_W : HSUM_W;
  localparam int DVS_W  = (CNT_W > HCNT_W) ? CNT_W : HCNT_W;

  svfm_pkg::back_state_t state_r, state_nxt;
  svfm_pkg::sample_t     item_r;

  logic [MW-1:0]         ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld_r;
  logic [RW-1:0]         ring_idx_r, scan_idx_r;
  logic [MW-1:0]         rd_raw_r;
  logic                  rd_vld_r;
  logic [MW-1:0]         mn_r, mx_r, fv_r;
  logic [SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]      cnt_r;

  logic [MW-1:0]         hist_r [HISTORY_DEPTH];
  logic [HW-1:0]         hidx_r, hscan_r;
  logic [HSUM_W-1:0]     hsum_r;
  logic [HCNT_W-1:0]     hcnt_r;

  logic [MW-1:0]                filt_r;
  logic [svfm_pkg::LVL_W-1:0]   level_r, before_r;
  logic [svfm_pkg::DEB_W-1:0]   worse_r, recov_r;
  logic                         out_valid_r;

  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dividend, div_quo;
  logic [DVS_W-1:0]  div_divisor;
  logic              load_out;

  // ring statistics helpers
  logic [MW-1:0] scan_s, spread, mid, fvc, quo_mv;
  logic [MW:0]   mxmn;
  logic [MW-2:0] half;
  logic          use_mean;
  logic [MW-1:0] hist_s;

  // level helpers
  logic [svfm_pkg::LVL_W-1:0] target;
  logic [MW-1:0]              thr_prev;
  logic [MW:0]                margin;

  assign scan_s   = rd_vld_r ? rd_raw_r : '0;
  assign spread   = mx_r - mn_r;
  assign mxmn     = {1'b0, mx_r} + {1'b0, mn_r};
  assign mid      = mxmn[MW:1];
  assign half     = spread[MW-1:1];
  assign use_mean = (spread > cfg.spread);
  assign hist_s   = hist_r[hscan_r];
  assign quo_mv   = (div_quo > DVD_W'(cfg.ceiling)) ? cfg.ceiling : div_quo[MW-1:0];

  always_comb begin
    logic [MW-1:0] t;
    t = (mid >= {1'b0, half}) ? (mid - {1'b0, half}) : '0;
    if (t < mn_r) t = mn_r;
    fvc = (t > cfg.ceiling) ? cfg.ceiling : t;
  end

  always_comb begin
    if (filt_r >= cfg.level1)      target = 2'd0;
    else if (filt_r >= cfg.level2) target = 2'd1;
    else if (filt_r >= cfg.level3) target = 2'd2;
    else                           target = 2'd3;
    case (level_r)
      2'd1:    thr_prev = cfg.level1;
      2'd2:    thr_prev = cfg.level2;
      default: thr_prev = cfg.level3;
    endcase
    margin = {1'b0, thr_prev} + (MW + 1)'(cfg.hyst);
  end

  svfm_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= svfm_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    pop          = 1'b0;
    div_start    = 1'b0;
    div_dividend = DVD_W'(sum_r);
    div_divisor  = DVS_W'(cnt_r);
    load_out     = 1'b0;
    unique case (state_r)
      svfm_pkg::ST_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          state_nxt = pop_data.acc ? svfm_pkg::ST_WRITE : svfm_pkg::ST_DONE;
        end
      end
      svfm_pkg::ST_WRITE: state_nxt = svfm_pkg::ST_SCAN;
      svfm_pkg::ST_SCAN: begin
        if (scan_idx_r == RW'(RING_DEPTH - 1)) state_nxt = svfm_pkg::ST_SCAN_END;
      end
      svfm_pkg::ST_SCAN_END: state_nxt = svfm_pkg::ST_RING_FV;
      svfm_pkg::ST_RING_FV: begin
        if (cnt_r != '0 && use_mean) begin
          div_start = 1'b1;
          state_nxt = svfm_pkg::ST_RING_DIV;
        end else begin
          state_nxt = svfm_pkg::ST_HIST_WRITE;
        end
      end
      svfm_pkg::ST_RING_DIV: begin
        if (div_done) state_nxt = svfm_pkg::ST_HIST_WRITE;
      end
      svfm_pkg::ST_HIST_WRITE: state_nxt = svfm_pkg::ST_HIST_SCAN;
      svfm_pkg::ST_HIST_SCAN: begin
        if (hscan_r == HW'(HISTORY_DEPTH - 1)) state_nxt = svfm_pkg::ST_HIST_FV;
      end
      svfm_pkg::ST_HIST_FV: begin
        div_dividend = DVD_W'(hsum_r);
        div_divisor  = DVS_W'(hcnt_r);
        if (hcnt_r != '0) begin
          div_start = 1'b1;
          state_nxt = svfm_pkg::ST_HIST_DIV;
        end else begin
          state_nxt = svfm_pkg::ST_LEVEL;
        end
      end
      svfm_pkg::ST_HIST_DIV: begin
        if (div_done) state_nxt = svfm_pkg::ST_LEVEL;
      end
      svfm_pkg::ST_LEVEL: state_nxt = svfm_pkg::ST_DONE;
      svfm_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = svfm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = svfm_pkg::ST_IDLE;
    endcase
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == svfm_pkg::ST_WRITE) ring_mem[ring_idx_r] <= item_r.mv;
    rd_raw_r <= ring_mem[scan_idx_r];
    rd_vld_r <= ring_vld_r[scan_idx_r];
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r   <= pop_data;
      before_r <= level_r;
    end
    case (state_r)
      svfm_pkg::ST_WRITE: begin
        scan_idx_r <= '0;
        mn_r  <= '0;
        mx_r  <= '0;
        sum_r <= '0;
        cnt_r <= '0;
      end
      svfm_pkg::ST_SCAN, svfm_pkg::ST_SCAN_END: begin
        if (state_r == svfm_pkg::ST_SCAN) scan_idx_r <= scan_idx_r + 1'b1;
        // first scan cycle has no read data yet
        if (!(state_r == svfm_pkg::ST_SCAN && scan_idx_r == '0) && scan_s != '0) begin
          if (cnt_r == '0 || scan_s < mn_r) mn_r <= scan_s;
          if (cnt_r == '0 || scan_s > mx_r) mx_r <= scan_s;
          sum_r <= sum_r + SUM_W'(scan_s);
          cnt_r <= cnt_r + 1'b1;
        end
      end
      svfm_pkg::ST_RING_FV: begin
        if (cnt_r == '0) fv_r <= cfg.ceiling;
        else if (!use_mean) fv_r <= fvc;
      end
      svfm_pkg::ST_RING_DIV: begin
        if (div_done) fv_r <= quo_mv;
      end
      svfm_pkg::ST_HIST_WRITE: begin
        hscan_r <= '0;
        hsum_r  <= '0;
        hcnt_r  <= '0;
      end
      svfm_pkg::ST_HIST_SCAN: begin
        hscan_r <= hscan_r + 1'b1;
        if (hist_s != '0) begin
          hsum_r <= hsum_r + HSUM_W'(hist_s);
          hcnt_r <= hcnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      ring_idx_r <= '0;
      hidx_r     <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_r[i] <= '0;
      filt_r     <= '0;
      level_r    <= '0;
      worse_r    <= '0;
      recov_r    <= '0;
    end else begin
      case (state_r)
        svfm_pkg::ST_WRITE: begin
          ring_vld_r[ring_idx_r] <= 1'b1;
          ring_idx_r <= (ring_idx_r == RW'(RING_DEPTH - 1)) ? '0 : ring_idx_r + 1'b1;
        end
        svfm_pkg::ST_HIST_WRITE: begin
          hist_r[hidx_r] <= fv_r;
          hidx_r <= (hidx_r == HW'(HISTORY_DEPTH - 1)) ? '0 : hidx_r + 1'b1;
        end
        svfm_pkg::ST_HIST_FV: begin
          if (hcnt_r == '0) filt_r <= cfg.ceiling;
        end
        svfm_pkg::ST_HIST_DIV: begin
          if (div_done) filt_r <= div_quo[MW-1:0];
        end
        svfm_pkg::ST_LEVEL: begin
          if (filt_r > svfm_pkg::ENGAGE_MIN_MV) begin
            if (target > level_r) begin
              if (worse_r >= cfg.debounce) level_r <= target;
              else worse_r <= worse_r + 1'b1;
              recov_r <= '0;
            end else if (target < level_r) begin
              if ({1'b0, filt_r} > margin) begin
                if (recov_r >= cfg.debounce) level_r <= level_r - 1'b1;
                else recov_r <= recov_r + 1'b1;
              end else begin
                recov_r <= '0;
              end
              worse_r <= '0;
            end else begin
              worse_r <= '0;
              recov_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.accepted      <= item_r.acc;
      out_ch.smoothed_mv   <= filt_r;
      out_ch.warn_level    <= level_r;
      out_ch.low_voltage   <= (level_r != '0);
      out_ch.level_changed <= (level_r != before_r);
    end
  end

  assign out_ch.valid = out_valid_r;
endmodule

>>> rtl/supply_voltage_filter_monitor.sv
// top level of the supply voltage filter monitor: config registers, front, queue, back
// depends on svfm_pkg, svfm_if, svfm_fifo, svfm_front, svfm_back
//
// One result per input sample. A sample that fails the 3000..7000 mV window or
// falls in warm-up skips the ring and history and goes from the queue straight
// to the result register. For a kept sample the ring is swept through its single
// read port one entry a cycle, and the mean, when the ring spread exceeds the
// limit, and the history average each go through a one-bit-per-cycle divider.
// A two-entry queue lets new samples enter while the back part works, and the
// result register holds a result until it is taken. Config writes are always
// ready and take effect at once; write them only while the block is idle.
module supply_voltage_filter_monitor #(
  parameter int RING_DEPTH    = 60,
  parameter int HISTORY_DEPTH = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  svfm_in_if.sink     in_ch,
  svfm_out_if.source  out_ch,
  svfm_cfg_if.sink    cfg_ch
);
  svfm_pkg::cfg_t    cfg_r;
  svfm_pkg::sample_t push_data, pop_data;
  logic push, pop, full, empty;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level1   <= svfm_pkg::RST_LEVEL1;
      cfg_r.level2   <= svfm_pkg::RST_LEVEL2;
      cfg_r.level3   <= svfm_pkg::RST_LEVEL3;
      cfg_r.hyst     <= svfm_pkg::RST_HYST;
      cfg_r.debounce <= svfm_pkg::RST_DEBOUNCE;
      cfg_r.warmup   <= svfm_pkg::RST_WARMUP;
      cfg_r.spread   <= svfm_pkg::RST_SPREAD;
      cfg_r.ceiling  <= svfm_pkg::RST_CEILING;
    end else if (cfg_ch.valid) begin
      unique case (svfm_pkg::cfg_idx_t'(cfg_ch.index))
        svfm_pkg::CFG_LEVEL1:   cfg_r.level1   <= cfg_ch.data;
        svfm_pkg::CFG_LEVEL2:   cfg_r.level2   <= cfg_ch.data;
        svfm_pkg::CFG_LEVEL3:   cfg_r.level3   <= cfg_ch.data;
        svfm_pkg::CFG_HYST:     cfg_r.hyst     <= cfg_ch.data[svfm_pkg::HYST_W-1:0];
        svfm_pkg::CFG_DEBOUNCE: cfg_r.debounce <= cfg_ch.data[svfm_pkg::DEB_W-1:0];
        svfm_pkg::CFG_WARMUP:   cfg_r.warmup   <= cfg_ch.data[svfm_pkg::WARM_W-1:0];
        svfm_pkg::CFG_SPREAD:   cfg_r.spread   <= cfg_ch.data;
        svfm_pkg::CFG_CEILING:  cfg_r.ceiling  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  svfm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  svfm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  svfm_back #(.RING_DEPTH(RING_DEPTH), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );
endmodule

>>> rtl/svfm_checker.sv
// port-level checks for the supply voltage filter monitor, bound to the top level
// depends on supply_voltage_filter_monitor_macros.svh and svfm_pkg
`include "supply_voltage_filter_monitor_macros.svh"

module svfm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       accepted,
  input logic [svfm_pkg::MV_W-1:0]  smoothed_mv,
  input logic [svfm_pkg::LVL_W-1:0] warn_level,
  input logic                       low_voltage,
  input logic                       level_changed
);
  // a stalled result holds
  `SVFM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable({accepted, smoothed_mv, warn_level, low_voltage, level_changed}))
  // the low flag follows the level
  `SVFM_ASSERT_NOW(a_low_flag, out_valid, low_voltage == (warn_level != '0))
  // a dropped sample never moves the level
  `SVFM_ASSERT_NOW(a_drop_steady, out_valid && !accepted, !level_changed)
endmodule

bind supply_voltage_filter_monitor svfm_checker u_svfm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .accepted      (out_ch.accepted),
  .smoothed_mv   (out_ch.smoothed_mv),
  .warn_level    (out_ch.warn_level),
  .low_voltage   (out_ch.low_voltage),
  .level_changed (out_ch.level_changed)
);
